[hdl/kcpm_pkg.sv]
// ----------------------------------------------------------------------------
// kcpm_pkg
// Shared types, constants and the byte-wide CRC-32 step for the pool mixer.
// ----------------------------------------------------------------------------
package kcpm_pkg;

	localparam int OPCODE_W = 2;
	localparam int IDX_W    = 6;
	localparam int BYTE_W   = 8;
	localparam int CNT_W    = 21;
	localparam int CRC_W    = 32;

	// pool is split into four byte banks, one per mixed CRC byte
	localparam int BANKS  = 4;
	localparam int BANK_W = 2;

	// result queue
	localparam int RSP_DEPTH = 4;
	localparam int RSP_PW    = 2;
	localparam int RSP_CW    = 3;

	localparam logic [CRC_W-1:0] CRC_POLY    = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0] CRC_INIT    = 32'hFFFF_FFFF;
	localparam logic [CNT_W-1:0] LIMIT_RESET = 21'd1048576;
	localparam logic [CNT_W-1:0] CNT_MAX     = 21'h1F_FFFF;

	typedef enum logic [OPCODE_W-1:0] {
		OP_WRITE = 2'd0,
		OP_MIX   = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} kcpm_op_t;

	// one bank access: overwrite (set) or add val to the stored byte
	typedef struct packed {
		logic              en;
		logic              set;
		logic [BYTE_W-1:0] val;
	} kcpm_lane_t;

	// per-access control traveling with the bank lanes
	typedef struct packed {
		logic              valid;
		logic              is_read;
		logic              oob;
		logic [BANK_W-1:0] bank;
	} kcpm_ctl_t;

	// reflected CRC-32, one byte
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
		end
		return c;
	endfunction

endpackage

[hdl/kcpm_ifs.sv]
// ----------------------------------------------------------------------------
// kcpm_ifs
// Valid/ready channels of the pool mixer: command words in, read words out.
// ----------------------------------------------------------------------------
interface kcpm_cmd_if import kcpm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [IDX_W-1:0]    pool_index;
	logic [BYTE_W-1:0]   data_byte;
	logic                first_of_file;

	modport source (output valid, opcode, pool_index, data_byte, first_of_file, input ready);
	modport sink (input valid, opcode, pool_index, data_byte, first_of_file, output ready);
endinterface

interface kcpm_rsp_if import kcpm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

[hdl/keyfile_crc_pool_mixer_unit.sv]
// ----------------------------------------------------------------------------
// keyfile_crc_pool_mixer_unit
// Mixes keyfile bytes into a password pool via CRC-32; pool write/read access.
// ----------------------------------------------------------------------------
//  channel  | dir | word                                           | handshake
//  ---------+-----+------------------------------------------------+----------
//  cmd      | in  | opcode, pool_index, data_byte, first_of_file   | valid/ready
//  rsp      | out | read_data (one word per read opcode)           | valid/ready
//  cfg      | in  | cfg_wdata = max_bytes_per_file                 | cfg_we
//
//  One cmd word per cycle while cmd.ready is high. A read word passes the pool
//  stage and the result queue to rsp. A mixed byte whose four pool bytes cross
//  the pool end takes a second pass when POOL_BYTES is not a multiple of four
//  (bank conflict in the four-bank pool). arst_n clears the CRC/position/count
//  state and the per-row valid bits, so the pool reads as zeros at once; no
//  clearing pass. rsp stalls are absorbed by a four-word result queue; cmd.ready
//  drops when it plus the pool-stage word would fill it, and in a second pass.
// ----------------------------------------------------------------------------
module keyfile_crc_pool_mixer_unit import kcpm_pkg::*; #(
	parameter int POOL_BYTES = 64,
	localparam int ROWS = (POOL_BYTES + BANKS - 1) / BANKS,
	localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	kcpm_cmd_if.sink         cmd,
	kcpm_rsp_if.source       rsp
);

	// issue stage -> pool: per-bank access and item control
	kcpm_lane_t [BANKS-1:0]   lane_s0;
	logic [BANKS-1:0][AW-1:0] row_s0;
	kcpm_ctl_t                ctl_s0;

	// pool -> result queue
	logic              push_valid;
	logic [BYTE_W-1:0] push_data;
	logic              room;

	// decode, CRC update, position/limit tracking
	kcpm_front #(
		.POOL_BYTES (POOL_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.room      (room),
		.lane_s0   (lane_s0),
		.row_s0    (row_s0),
		.ctl_s0    (ctl_s0)
	);

	// banked pool: read at accept, add/overwrite in the following cycle
	kcpm_pool #(
		.POOL_BYTES (POOL_BYTES)
	) u_pool (
		.clk        (clk),
		.arst_n     (arst_n),
		.lane_s0    (lane_s0),
		.row_s0     (row_s0),
		.ctl_s0     (ctl_s0),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	// read words wait here for the rsp side
	kcpm_rsp_q u_rsp_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.rsp        (rsp),
		.room       (room)
	);

endmodule

[hdl/kcpm_ram.sv]
// ----------------------------------------------------------------------------
// kcpm_ram
// Generic single-write, single-read RAM; registered read, old data on collision.
// ----------------------------------------------------------------------------
module kcpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/kcpm_front.sv]
// ----------------------------------------------------------------------------
// kcpm_front
// Command decode, CRC/position/count state and bank access issue.
// ----------------------------------------------------------------------------
module kcpm_front import kcpm_pkg::*; #(
	parameter int POOL_BYTES = 64,
	localparam int PW = $clog2(POOL_BYTES),
	localparam int ROWS = (POOL_BYTES + BANKS - 1) / BANKS,
	localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CNT_W-1:0]            cfg_wdata,
	kcpm_cmd_if.sink                    cmd,
	input  logic                        room,
	output kcpm_lane_t [BANKS-1:0]      lane_s0,
	output logic [BANKS-1:0][AW-1:0]    row_s0,
	output kcpm_ctl_t                   ctl_s0
);

	// wrap can put two CRC bytes in one bank only if the pool is not a multiple of four
	localparam bit SPLIT = (POOL_BYTES % BANKS) != 0;
	localparam logic [PW-1:0] LAST = PW'(POOL_BYTES - 1);

	logic [CRC_W-1:0] crc_q;
	logic [PW-1:0]    pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] max_q;
	logic             pend_q;
	kcpm_lane_t [BANKS-1:0]   pend_lane_q;
	logic [BANKS-1:0][AW-1:0] pend_row_q;

	logic             accept;
	kcpm_op_t         op;
	logic             idx_ok;
	logic [BANK_W-1:0] idx_bank;
	logic [AW-1:0]    idx_row;
	logic [CRC_W-1:0] crc_base, crc_new, crc_out;
	logic [CNT_W-1:0] cnt_base, cnt_inc;
	logic             go;
	logic [BANKS:0][PW-1:0] pos_k;
	logic [BANKS-1:0] wrapped;
	kcpm_lane_t [BANKS-1:0]   mix_a, mix_b;
	logic [BANKS-1:0][AW-1:0] row_a, row_b;
	logic             split_any;

	assign cmd.ready = room && !pend_q;
	assign accept    = cmd.valid && cmd.ready;
	assign op        = kcpm_op_t'(cmd.opcode);
	assign idx_ok    = 32'(cmd.pool_index) < 32'(POOL_BYTES);
	assign idx_bank  = cmd.pool_index[BANK_W-1:0];
	assign idx_row   = AW'(cmd.pool_index >> BANK_W);

	// file restart folds into the base values
	assign crc_base = cmd.first_of_file ? CRC_INIT : crc_q;
	assign cnt_base = cmd.first_of_file ? '0 : cnt_q;
	assign go       = (cnt_base == '0) || (cnt_base < max_q);
	assign crc_new  = crc_byte(crc_base, cmd.data_byte);
	assign crc_out  = ~crc_new;
	assign cnt_inc  = cnt_base + CNT_W'(cnt_base != CNT_MAX);

	// four pool positions, wrapping at the pool end
	always_comb begin
		pos_k[0]   = cmd.first_of_file ? '0 : pos_q;
		wrapped[0] = 1'b0;
		for (int k = 0; k < BANKS; k++) begin
			pos_k[k+1] = (pos_k[k] == LAST) ? '0 : pos_k[k] + 1'b1;
		end
		for (int k = 1; k < BANKS; k++) begin
			wrapped[k] = wrapped[k-1] | (pos_k[k-1] == LAST);
		end
	end

	// bytes after a wrap go to a second pass when banks could collide
	always_comb begin
		mix_a     = '0;
		mix_b     = '0;
		row_a     = '0;
		row_b     = '0;
		split_any = 1'b0;
		for (int k = 0; k < BANKS; k++) begin
			if (SPLIT && wrapped[k]) begin
				mix_b[pos_k[k][BANK_W-1:0]].en  = 1'b1;
				mix_b[pos_k[k][BANK_W-1:0]].val = crc_out[CRC_W-1-BYTE_W*k -: BYTE_W];
				row_b[pos_k[k][BANK_W-1:0]]     = AW'(pos_k[k] >> BANK_W);
				split_any = 1'b1;
			end else begin
				mix_a[pos_k[k][BANK_W-1:0]].en  = 1'b1;
				mix_a[pos_k[k][BANK_W-1:0]].val = crc_out[CRC_W-1-BYTE_W*k -: BYTE_W];
				row_a[pos_k[k][BANK_W-1:0]]     = AW'(pos_k[k] >> BANK_W);
			end
		end
	end

	always_comb begin
		lane_s0 = '0;
		row_s0  = '0;
		ctl_s0  = '0;
		if (pend_q) begin
			lane_s0      = pend_lane_q;
			row_s0       = pend_row_q;
			ctl_s0.valid = 1'b1;
		end else if (accept) begin
			unique case (op)
				OP_WRITE: begin
					if (idx_ok) begin
						lane_s0[idx_bank].en  = 1'b1;
						lane_s0[idx_bank].set = 1'b1;
						lane_s0[idx_bank].val = cmd.data_byte;
						row_s0[idx_bank]      = idx_row;
						ctl_s0.valid          = 1'b1;
					end
				end
				OP_MIX: begin
					if (go) begin
						lane_s0      = mix_a;
						row_s0       = row_a;
						ctl_s0.valid = 1'b1;
					end
				end
				OP_READ: begin
					ctl_s0.valid   = 1'b1;
					ctl_s0.is_read = 1'b1;
					ctl_s0.oob     = !idx_ok;
					ctl_s0.bank    = idx_bank;
					if (idx_ok) begin
						row_s0[idx_bank] = idx_row;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			pos_q  <= '0;
			cnt_q  <= '0;
			max_q  <= LIMIT_RESET;
			pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			pend_q <= 1'b0;
			if (accept && op == OP_MIX) begin
				crc_q  <= go ? crc_new : crc_base;
				pos_q  <= go ? pos_k[BANKS] : pos_k[0];
				cnt_q  <= go ? cnt_inc : cnt_base;
				pend_q <= go && split_any;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_lane_q <= mix_b;
			pend_row_q  <= row_b;
		end
	end

`ifndef ASSERT_OFF
	a_pend_after_mix: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> $past(accept && op == OP_MIX))
		else $error("second pass without a mixed word");
	a_pend_single: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> !pend_q)
		else $error("second pass lasted more than one cycle");
`endif

endmodule

[hdl/kcpm_pool.sv]
// ----------------------------------------------------------------------------
// kcpm_pool
// Four banked pool RAMs with read-modify-write, valid bits and write bypass.
// ----------------------------------------------------------------------------
module kcpm_pool import kcpm_pkg::*; #(
	parameter int POOL_BYTES = 64,
	localparam int ROWS = (POOL_BYTES + BANKS - 1) / BANKS,
	localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kcpm_lane_t [BANKS-1:0]   lane_s0,
	input  logic [BANKS-1:0][AW-1:0] row_s0,
	input  kcpm_ctl_t                ctl_s0,
	output logic                     push_valid,
	output logic [BYTE_W-1:0]        push_data
);

	kcpm_lane_t [BANKS-1:0]   lane_s1;
	logic [BANKS-1:0][AW-1:0] row_s1;
	kcpm_ctl_t                ctl_s1;
	logic [BANKS-1:0]         vld_s1;
	logic [BANKS-1:0][ROWS-1:0] vld_q;
	logic [BANKS-1:0]         fwd_en_q;
	logic [BANKS-1:0][AW-1:0] fwd_row_q;
	logic [BANKS-1:0][BYTE_W-1:0] fwd_data_q;

	logic [BANKS-1:0][BYTE_W-1:0] rd_data, old_byte, new_byte;
	logic [BANKS-1:0]             we;

	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		kcpm_ram #(
			.WIDTH (BYTE_W),
			.DEPTH (ROWS)
		) u_ram (
			.clk   (clk),
			.we    (we[b]),
			.waddr (row_s1[b]),
			.wdata (new_byte[b]),
			.re    (ctl_s0.valid),
			.raddr (row_s0[b]),
			.rdata (rd_data[b])
		);
	end

	// bypass covers the write that lands on the same edge as the read
	always_comb begin
		for (int b = 0; b < BANKS; b++) begin
			if (fwd_en_q[b] && fwd_row_q[b] == row_s1[b]) begin
				old_byte[b] = fwd_data_q[b];
			end else begin
				old_byte[b] = vld_s1[b] ? rd_data[b] : '0;
			end
			new_byte[b] = lane_s1[b].set ? lane_s1[b].val : old_byte[b] + lane_s1[b].val;
			we[b]       = ctl_s1.valid && lane_s1[b].en;
		end
	end

	assign push_valid = ctl_s1.valid && ctl_s1.is_read;
	assign push_data  = ctl_s1.oob ? '0 : old_byte[ctl_s1.bank];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			fwd_en_q <= '0;
			vld_q    <= '0;
		end else begin
			ctl_s1   <= ctl_s0;
			fwd_en_q <= we;
			for (int b = 0; b < BANKS; b++) begin
				if (we[b]) begin
					vld_q[b][row_s1[b]] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		lane_s1    <= lane_s0;
		row_s1     <= row_s0;
		fwd_row_q  <= row_s1;
		fwd_data_q <= new_byte;
		for (int b = 0; b < BANKS; b++) begin
			vld_s1[b] <= vld_q[b][row_s0[b]];
		end
	end

`ifndef ASSERT_OFF
	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.valid && ctl_s1.is_read) |-> (we == '0))
		else $error("pool write issued by a read word");
`endif

endmodule

[hdl/kcpm_rsp_q.sv]
// ----------------------------------------------------------------------------
// kcpm_rsp_q
// Four-entry result queue between the pool and the read channel.
// ----------------------------------------------------------------------------
module kcpm_rsp_q import kcpm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  logic [BYTE_W-1:0] push_data,
	kcpm_rsp_if.source        rsp,
	output logic              room
);

	logic [BYTE_W-1:0] mem_q [RSP_DEPTH];
	logic [RSP_PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [RSP_CW-1:0] count_q;
	logic              pop;

	assign rsp.valid     = count_q != '0;
	assign rsp.read_data = mem_q[rd_ptr_q];
	assign pop           = rsp.valid && rsp.ready;

	// one more word may still be in the pool stage
	assign room = (count_q + RSP_CW'(push_valid)) < RSP_CW'(RSP_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RSP_PW'(push_valid);
			rd_ptr_q <= rd_ptr_q + RSP_PW'(pop);
			count_q  <= count_q + RSP_CW'(push_valid) - RSP_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (count_q != RSP_CW'(RSP_DEPTH)))
		else $error("result queue overflow");
`endif

endmodule

[sim/tb_keyfile_crc_pool_mixer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyfile_crc_pool_mixer_unit
// Drives command words into the pool mixer and checks every read word
// against a cycle-free model of the pool, the CRC and the per-file byte count.
// ----------------------------------------------------------------------------
module tb_keyfile_crc_pool_mixer_unit import kcpm_pkg::*; ();

	localparam int POOL_SIZE   = 64;
	localparam int CYCLE_LIMIT = 200_000;
	localparam int HOLD_CYCLES = 300;  // long receiver hold-off
	localparam int DRAIN_WAIT  = 8;    // mixes have no word
	localparam int PHASE_WORDS = 85;

	// ------------------------------------------------------------------------
	// Pool model: predicts read words, queues them, checks the returned ones.
	// ------------------------------------------------------------------------
	class pool_scoreboard;
		logic [BYTE_W-1:0] pool [POOL_SIZE];
		logic [CRC_W-1:0]  crc;
		logic [IDX_W-1:0]  pos;     // 6 bits, wraps with the 64-byte pool
		logic [CNT_W-1:0]  count;
		logic [CNT_W-1:0]  limit;
		logic [BYTE_W-1:0] pending_reads [$];
		int                errors;

		function new();
			foreach (pool[i]) pool[i] = '0;
			limit  = LIMIT_RESET;
			errors = 0;
			restart_file();
		endfunction

		function void restart_file();
			crc   = CRC_INIT;
			pos   = '0;
			count = '0;
		endfunction

		function void set_limit(logic [CNT_W-1:0] v);
			limit = v;
		endfunction

		function logic [CRC_W-1:0] crc32_update(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
			logic [CRC_W-1:0] r;
			r = c ^ {24'h0, b};
			for (int k = 0; k < 8; k++)
				r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
			return r;
		endfunction

		// a limit of zero still lets the first byte through
		function void mix_byte(logic [BYTE_W-1:0] b);
			logic [CRC_W-1:0] digest;
			if (count != 0 && count >= limit)
				return;
			crc    = crc32_update(crc, b);
			digest = ~crc;
			for (int s = 3; s >= 0; s--) begin
				pool[pos] = pool[pos] + digest[s*8 +: 8];
				pos++;
			end
			if (count != CNT_MAX)
				count++;
		endfunction

		function void note_command(logic [OPCODE_W-1:0] op, logic [IDX_W-1:0] idx,
			logic [BYTE_W-1:0] data, logic first);
			case (kcpm_op_t'(op))
				OP_WRITE: pool[idx] = data;
				OP_MIX: begin
					if (first)
						restart_file();
					mix_byte(data);
				end
				OP_READ: pending_reads.push_back(pool[idx]);
				default: ;
			endcase
		endfunction

		function void check_read(logic [BYTE_W-1:0] got);
			logic [BYTE_W-1:0] want;
			if (pending_reads.size() == 0) begin
				$display("%0t: unexpected read word, expected none, actual %02h", $time, got);
				errors++;
				return;
			end
			want = pending_reads.pop_front();
			if (got !== want) begin
				$display("%0t: read_data mismatch, expected %02h, actual %02h",
					$time, want, got);
				errors++;
			end
		endfunction

		function int waiting();
			return pending_reads.size();
		endfunction

		function void flag_leftovers();
			while (pending_reads.size() != 0) begin
				$display("%0t: read word never returned, expected %02h, actual none",
					$time, pending_reads.pop_front());
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	kcpm_cmd_if cmd_ch ();
	kcpm_rsp_if rsp_ch ();

	keyfile_crc_pool_mixer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	pool_scoreboard sb;

	bit idle_on;        // random idling on both sides when set
	int stall_req;      // bumped by the stimulus to ask for a receiver hold-off
	int stall_done;
	int file_left;      // keyfile bytes left in the file being streamed
	int cycle_count;

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random ready, plus one long hold-off on request. The hold is
	// counted here so the sender keeps pushing reads while rsp is blocked,
	// which fills the result queue and must pull cmd.ready low.
	// ------------------------------------------------------------------------
	initial begin
		rsp_ch.ready = 1'b0;
		stall_done   = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_req != stall_done) begin
				rsp_ch.ready <= 1'b0;
				for (int n = 1; n < HOLD_CYCLES; n++)
					@(posedge clk);
				stall_done = stall_req;
			end else begin
				rsp_ch.ready <= !(idle_on && $urandom_range(99) < 10);
			end
		end
	end

	// Read words are checked at the falling edge ahead of the accepting edge, when
	// valid, ready and read_data are settled.
	always @(negedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_read(rsp_ch.read_data);
	end

	// ------------------------------------------------------------------------
	// Sender. Called at a rising edge; returns at the edge that accepts the
	// word, so the next word can be put up in the same step.
	// ------------------------------------------------------------------------
	task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [IDX_W-1:0] idx,
		input logic [BYTE_W-1:0] data, input logic first);
		bit taken;
		while (idle_on && $urandom_range(99) < 10) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid         <= 1'b1;
		cmd_ch.opcode        <= op;
		cmd_ch.pool_index    <= idx;
		cmd_ch.data_byte     <= data;
		cmd_ch.first_of_file <= first;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cmd_ch.ready;
			if (taken)
				sb.note_command(op, idx, data, first);
			@(posedge clk);
		end
	endtask

	// Let every read come back, then give in-flight mixes time to land.
	task automatic drain_block();
		cmd_ch.valid <= 1'b0;
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// limit register is only touched with the block idle
	task automatic write_limit(input logic [CNT_W-1:0] v);
		drain_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(v);
	endtask

	// Mostly keyfiles streamed as marked-first byte plus a run of bytes, with
	// reads and password writes mixed in; a little noise on top.
	task automatic random_word();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			if (file_left == 0) begin
				file_left = $urandom_range(1, 40);
				send_word(OP_MIX, 6'($urandom), 8'($urandom), 1'b1);
			end else begin
				send_word(OP_MIX, 6'($urandom), 8'($urandom), 1'b0);
			end
			file_left--;
		end else if (pick < 75) begin
			send_word(OP_READ, 6'($urandom), 8'($urandom), 1'($urandom));
		end else if (pick < 90) begin
			// zero padding shows up as zero writes
			send_word(OP_WRITE, 6'($urandom),
				($urandom_range(4) == 0) ? 8'h00 : 8'($urandom), 1'($urandom));
		end else if (pick < 95) begin
			// stray byte with a random first mark, breaks the running file
			send_word(OP_MIX, 6'($urandom), 8'($urandom), 1'($urandom));
		end else begin
			send_word(OP_NONE, 6'($urandom), 8'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		logic [CNT_W-1:0] limit_plan [7];

		sb                   = new();
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		cmd_ch.valid         = 1'b0;
		cmd_ch.opcode        = '0;
		cmd_ch.pool_index    = '0;
		cmd_ch.data_byte     = '0;
		cmd_ch.first_of_file = 1'b0;
		idle_on              = 1'b1;
		stall_req            = 0;
		file_left            = 0;
		cycle_count          = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset limit ---
		send_word(OP_WRITE, 6'd0, 8'hFF, 1'b0);
		send_word(OP_WRITE, 6'd63, 8'h00, 1'b1);
		send_word(OP_WRITE, 6'd1, 8'h80, 1'b0);
		send_word(OP_READ, 6'd0, 8'h00, 1'b0);
		send_word(OP_READ, 6'd63, 8'hFF, 1'b1);
		send_word(OP_READ, 6'd40, 8'h00, 1'b0);    // never written, reset zero
		// bytes ahead of any marked first byte mix from the reset state
		send_word(OP_MIX, 6'd0, 8'h00, 1'b0);
		send_word(OP_MIX, 6'd63, 8'hFF, 1'b0);
		send_word(OP_READ, 6'd0, 8'h00, 1'b0);
		send_word(OP_READ, 6'd4, 8'h00, 1'b0);
		send_word(OP_NONE, 6'd63, 8'hFF, 1'b1);    // unused opcode, no word back
		send_word(OP_MIX, 6'd0, 8'h31, 1'b1);
		send_word(OP_MIX, 6'd0, 8'hA5, 1'b0);
		for (int i = 0; i < 4; i++)
			send_word(OP_READ, 6'(i), 8'h00, 1'b0);
		send_word(OP_WRITE, 6'd63, 8'hFF, 1'b0);
		send_word(OP_READ, 6'd63, 8'h00, 1'b0);

		// limit of zero behaves as one: the second byte is dropped
		write_limit('0);
		send_word(OP_MIX, 6'd0, 8'h55, 1'b1);
		send_word(OP_MIX, 6'd0, 8'hAA, 1'b0);
		send_word(OP_READ, 6'd0, 8'h00, 1'b0);
		send_word(OP_READ, 6'd4, 8'h00, 1'b0);

		// --- random phases over several limits, extremes included ---
		limit_plan = '{21'd1, 21'd3, 21'd17, CNT_MAX, LIMIT_RESET,
			21'($urandom_range(2, 64)), 21'd0};
		foreach (limit_plan[p]) begin
			write_limit(limit_plan[p]);
			idle_on = (p != 3);    // one phase runs without any idling
			if (p == 2) begin
				// receiver blocks for a long stretch while reads keep coming
				stall_req++;
				for (int i = 0; i < 40; i++)
					send_word(OP_READ, 6'($urandom), 8'($urandom), 1'($urandom));
			end
			for (int i = 0; i < PHASE_WORDS; i++)
				random_word();
		end
		idle_on = 1'b1;

		drain_block();
		sb.flag_leftovers();
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
